[rtl/clfp_pkg.sv]
// Shared types and constants for the comma-led decimal field parser.
`timescale 1ns / 1ps
package clfp_pkg;

    localparam int DEF_NUM_FIELDS  = 8;
    localparam int DEF_FIELD_CHARS = 7;
    localparam int QUEUE_DEPTH     = 4;

    localparam int INDEX_W = 3;
    localparam int VALUE_W = 25;
    localparam int ACC_W   = 24;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 32;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // classified character, as it travels from front to back
    typedef struct packed {
        logic       eob;
        logic       comma;
        logic       space;
        logic       ws;
        logic       sign;
        logic       minus;
        logic       digit;
        logic [3:0] dval;
    } t_tok;

    typedef enum logic [3:0] {
        SC_SKIP   = 4'b0001,
        SC_SIGN   = 4'b0010,
        SC_DIGITS = 4'b0100,
        SC_STOP   = 4'b1000
    } t_scan;

endpackage

[rtl/clfp_front.sv]
// Front end: takes input beats and classifies each character into a token.
`timescale 1ns / 1ps
module clfp_front
    import clfp_pkg::*;
(
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,   // [7:0] char_byte
    input  logic            s_axis_tlast,
    input  logic            i_q_full,
    output logic            o_push,
    output t_tok            o_tok
);

    logic [7:0] w_c;

    assign w_c           = s_axis_tdata;
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_tok.eob   = s_axis_tlast;
        o_tok.comma = (w_c == CHAR_COMMA);
        o_tok.space = (w_c == CHAR_SPACE);
        // tab, lf, vt, ff, cr and space all count as leading whitespace
        o_tok.ws    = (w_c == CHAR_SPACE) || (w_c >= CHAR_TAB && w_c <= CHAR_CR);
        o_tok.sign  = (w_c == CHAR_PLUS) || (w_c == CHAR_MINUS);
        o_tok.minus = (w_c == CHAR_MINUS);
        o_tok.digit = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
        o_tok.dval  = 4'(w_c - CHAR_ZERO);
    end

endmodule

[rtl/clfp_queue.sv]
// Short token queue between the classifier and the field parser.
`timescale 1ns / 1ps
module clfp_queue
    import clfp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_tok i_tok,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_tok o_tok
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_tok          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

endmodule

[rtl/clfp_back.sv]
// Back end: field sequencing, %ld style scan and the result register.
`timescale 1ns / 1ps
module clfp_back
    import clfp_pkg::*;
#(
    parameter int NUM_FIELDS  = DEF_NUM_FIELDS,
    parameter int FIELD_CHARS = DEF_FIELD_CHARS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    input  t_tok             i_tok,
    output logic             o_tok_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int PH_W = $clog2(NUM_FIELDS + 2);
    localparam int CC_W = $clog2(FIELD_CHARS + 1);
    localparam int PR_W = ACC_W + 4;

    // phase: 0 waits for comma, 1..NUM_FIELDS reads a field, NUM_FIELDS+1 done
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [CC_W-1:0]  r_cnt, n_cnt;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_neg, n_neg;
    t_scan            r_scan, n_scan;
    logic             r_ovf, n_ovf;
    logic             r_dig, n_dig;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_last;

    logic               w_pop;
    logic               w_emit;
    logic [PR_W-1:0]    w_prod;
    logic [ACC_W-1:0]   w_acc_dig;
    logic [PH_W-1:0]    w_idx;
    logic [ACC_W-1:0]   w_mag;
    logic [VALUE_W-1:0] w_val;
    logic [OUT_W-1:0]   w_data;
    logic               w_last;

    assign w_pop     = i_tok_valid && (!r_out_valid || m_axis_tready);
    assign o_tok_pop = w_pop;

    // times ten plus digit, saturating at the 24-bit maximum
    assign w_prod    = ({{(PR_W-ACC_W){1'b0}}, r_acc} << 3)
                     + ({{(PR_W-ACC_W){1'b0}}, r_acc} << 1)
                     + {{(PR_W-4){1'b0}}, i_tok.dval};
    assign w_acc_dig = (|w_prod[PR_W-1:ACC_W]) ? {ACC_W{1'b1}} : w_prod[ACC_W-1:0];

    assign w_idx  = r_phase - 1'b1;
    assign w_mag  = r_dig ? r_acc : '0;
    assign w_val  = r_neg ? (VALUE_W'(0) - {1'b0, w_mag}) : {1'b0, w_mag};
    assign w_last = (w_idx == PH_W'(NUM_FIELDS - 1));
    assign w_data = {{(OUT_W-INDEX_W-VALUE_W-2){1'b0}}, r_ovf, r_dig, w_val,
                     INDEX_W'(w_idx)};

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_scan  = r_scan;
        n_ovf   = r_ovf;
        n_dig   = r_dig;
        w_emit  = 1'b0;

        if (w_pop) begin
            if (r_phase == '0) begin
                if (i_tok.comma) begin
                    n_phase = PH_W'(1);
                    n_cnt = '0; n_acc = '0; n_neg = 1'b0;
                    n_scan = SC_SKIP; n_ovf = 1'b0; n_dig = 1'b0;
                end
            end else if (r_phase <= PH_W'(NUM_FIELDS)) begin
                if (i_tok.comma) begin
                    n_phase = PH_W'(1);
                    n_cnt = '0; n_acc = '0; n_neg = 1'b0;
                    n_scan = SC_SKIP; n_ovf = 1'b0; n_dig = 1'b0;
                end else if (i_tok.space) begin
                    w_emit  = 1'b1;
                    n_phase = r_phase + 1'b1;
                    n_cnt = '0; n_acc = '0; n_neg = 1'b0;
                    n_scan = SC_SKIP; n_ovf = 1'b0; n_dig = 1'b0;
                end else if (r_cnt < CC_W'(FIELD_CHARS)) begin
                    n_cnt = r_cnt + 1'b1;
                    case (r_scan)
                        SC_SKIP: begin
                            if (i_tok.ws) begin
                                n_scan = SC_SKIP;
                            end else if (i_tok.sign) begin
                                n_neg  = i_tok.minus;
                                n_scan = SC_SIGN;
                            end else if (i_tok.digit) begin
                                n_acc  = w_acc_dig;
                                n_dig  = 1'b1;
                                n_scan = SC_DIGITS;
                            end else begin
                                n_scan = SC_STOP;
                            end
                        end
                        SC_SIGN, SC_DIGITS: begin
                            if (i_tok.digit) begin
                                n_acc  = w_acc_dig;
                                n_dig  = 1'b1;
                                n_scan = SC_DIGITS;
                            end else begin
                                n_scan = SC_STOP;
                            end
                        end
                        default: begin
                            n_scan = r_scan;
                        end
                    endcase
                end else begin
                    n_ovf = 1'b1;
                end
            end

            if (i_tok.eob) begin
                n_phase = '0;
                n_cnt = '0; n_acc = '0; n_neg = 1'b0;
                n_scan = SC_SKIP; n_ovf = 1'b0; n_dig = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_scan      <= SC_SKIP;
            r_ovf       <= 1'b0;
            r_dig       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_scan  <= n_scan;
            r_ovf   <= n_ovf;
            r_dig   <= n_dig;
            if (w_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_emit) begin
            r_out_data <= w_data;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

[rtl/comma_led_decimal_field_parser.sv]
// Top level of the comma-led decimal field parser.
//
// Channel   Direction  tdata (low bit up)                          Other
// s_axis    in         char_byte[7:0]                              tlast = end_of_buffer
// m_axis    out        field_index[2:0], field_value[27:3],        tlast = last
//                      value_valid[28], too_long[29], zero[31:30]
//
// One character per cycle sustained while output beats are taken. The classifier is
// combinational; each beat is registered in the token queue before the parser takes it.
// A result is registered in the output register as the parser takes its closing space beat.
// The parser stalls only while the output register holds an untaken beat;
// the four-entry queue keeps the input side moving meanwhile.
// Synchronous active-low reset clears the queue, parser state and output valid.
`timescale 1ns / 1ps
module comma_led_decimal_field_parser
    import clfp_pkg::*;
#(
    parameter int NUM_FIELDS  = DEF_NUM_FIELDS,
    parameter int FIELD_CHARS = DEF_FIELD_CHARS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [2:0] index, [27:3] value,
                                             // [28] value_valid, [29] too_long
    output logic             m_axis_tlast
);

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_tok w_tok_in;
    t_tok w_tok_out;

    clfp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_tok         (w_tok_in)
    );

    clfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_tok_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_tok   (w_tok_out)
    );

    clfp_back #(
        .NUM_FIELDS  (NUM_FIELDS),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok_valid   (w_q_valid),
        .i_tok         (w_tok_out),
        .o_tok_pop     (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/clfp_checker.sv]
// Port-level checks for the comma-led decimal field parser, bound to the top.
`timescale 1ns / 1ps
module clfp_checker
    import clfp_pkg::*;
#(
    parameter int NUM_FIELDS = DEF_NUM_FIELDS
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tlast == (m_axis_tdata[2:0] == INDEX_W'(NUM_FIELDS - 1))))
        else $error("tlast does not match final field index");

    a_novalue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[28] |-> (m_axis_tdata[27:3] == '0))
        else $error("value nonzero without digits");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:30] == 2'b00))
        else $error("padding bits set");

endmodule

bind comma_led_decimal_field_parser clfp_checker #(
    .NUM_FIELDS (NUM_FIELDS)
) u_clfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
